FILE: hdl/periodic_neighbor_search_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic neighbor search core
// Shared shorthand for clocked checks; the user provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_NEIGHBOR_SEARCH_CORE_DEFINES_SVH
`define PERIODIC_NEIGHBOR_SEARCH_CORE_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define PNS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pns_pkg.sv
// ----------------------------------------------------------------------------
// pns_pkg
// Widths, register codes, control types and defaults of the neighbor search.
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

  // field widths
  localparam int COORD_W    = 24;
  localparam int PERIOD_W   = 23;
  localparam int IDX_W      = 6;
  localparam int SHIFT_W    = 2;
  localparam int COUNT_W    = 7;
  localparam int TGT_W      = 24;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // fixed point
  localparam int COORD_FRAC_BITS = 16;
  localparam int SQ_SHIFT        = 2 * COORD_FRAC_BITS - 16;

  // datapath: one axis difference, its square, the three-axis sum
  localparam int D_W     = COORD_W + 2;
  localparam int ACC_W   = 2 * D_W;
  localparam int TSUM_W  = TGT_W + SQ_SHIFT + 1;
  localparam int CMP_W   = ((ACC_W > TSUM_W) ? ACC_W : TSUM_W) + 1;

  // parameter defaults
  localparam int MAX_ATOMS_DEF     = 64;
  localparam int MAX_NEIGHBORS_DEF = 16;

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(65536);
  localparam logic [COUNT_W-1:0]  COUNT_RST  = COUNT_W'(8);
  localparam logic [TGT_W-1:0]    TGT_RST    = TGT_W'(12288);
  localparam logic [TOL_W-1:0]    TOL_RST    = TOL_W'(66);

  // image shift codes
  localparam logic signed [SHIFT_W-1:0] SHIFT_NEG  = 2'sb11;
  localparam logic signed [SHIFT_W-1:0] SHIFT_ZERO = 2'sb00;
  localparam logic signed [SHIFT_W-1:0] SHIFT_POS  = 2'sb01;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_X   = 3'd0,
    CFG_PERIOD_Y   = 3'd1,
    CFG_PERIOD_Z   = 3'd2,
    CFG_ATOM_COUNT = 3'd3,
    CFG_TARGET_SQ  = 3'd4,
    CFG_TOLERANCE  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_SQ,
    OP_ACC
  } dist_op_e;

  typedef struct packed {
    dist_op_e op;
    logic     first;
  } dist_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/pns_dist_unit.sv
// ----------------------------------------------------------------------------
// pns_dist_unit
// Shared squared-distance unit: one axis difference or one square per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_dist_unit (
  input  wire logic                                 clk_i,
  input  wire pns_pkg::dist_ctl_t                   ctl_i,
  input  wire logic signed [pns_pkg::COORD_W-1:0]   coord_i,
  input  wire logic signed [pns_pkg::SHIFT_W-1:0]   shift_i,
  input  wire logic        [pns_pkg::PERIOD_W-1:0]  period_i,
  input  wire logic signed [pns_pkg::COORD_W-1:0]   center_i,
  input  wire logic        [pns_pkg::TGT_W-1:0]     target_i,
  input  wire logic        [pns_pkg::TOL_W-1:0]     tol_i,
  output logic                                      match_o
);
  import pns_pkg::*;

  logic signed [D_W-1:0]   d_q;
  logic        [ACC_W-1:0] sq_q;
  logic        [ACC_W-1:0] acc_q;
  logic signed [CMP_W-1:0] lo_q, hi_q;

  logic signed [D_W-1:0]   shift_term;
  logic signed [D_W-1:0]   diff;
  logic signed [ACC_W-1:0] prod;
  logic signed [CMP_W-1:0] tgt_e, tol_e, acc_e;

  always_comb begin
    case (shift_i)
      SHIFT_POS: shift_term = $signed(D_W'(period_i));
      SHIFT_NEG: shift_term = -$signed(D_W'(period_i));
      default:   shift_term = '0;
    endcase
  end

  assign diff  = D_W'(coord_i) + shift_term - D_W'(center_i);
  assign prod  = ACC_W'(d_q) * ACC_W'(d_q);
  assign tgt_e = $signed(CMP_W'(target_i)) <<< SQ_SHIFT;
  assign tol_e = $signed(CMP_W'(tol_i)) <<< SQ_SHIFT;
  assign acc_e = $signed(CMP_W'(acc_q));

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        lo_q <= tgt_e - tol_e;
        hi_q <= tgt_e + tol_e;
      end
      OP_DIFF: begin
        d_q   <= diff;
        // fold in the previous axis square
        acc_q <= ctl_i.first ? '0 : acc_q + sq_q;
      end
      OP_SQ:  sq_q  <= $unsigned(prod);
      OP_ACC: acc_q <= acc_q + sq_q;
      default: ;
    endcase
  end

  // |d^2 - target| <= tol, as a window test
  assign match_o = (acc_e >= lo_q) && (acc_e <= hi_q);

endmodule

`default_nettype wire

FILE: hdl/periodic_neighbor_search_core.sv
// ----------------------------------------------------------------------------
// periodic_neighbor_search_core
// Neighbor finder over 27 periodic images of a stored set of atoms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one item per command. A store
//   item writes the x/y/z coordinates of slot atom_index_i, producing
//   nothing. A query item searches all slots below atom_count in the 27
//   images around the named atom.
//   Output channel (out_valid_o / out_stall_i): each matching image is one
//   item, ordered by shift x, y, z (-1, 0, +1) then index; last_o marks the
//   final one. No match gives a single item with found_o low. Past
//   MAX_NEIGHBORS matches the list is cut and overflow_o is set on all.
//   Config channel (cfg_valid_i / cfg_ready_o): always ready; write only
//   while the block is idle.
// Datapath: one squared-distance unit with a single 26x26 multiplier serves
//   all three axes; each tested image is fetched, then takes a difference
//   and a square per axis, an accumulate and a compare. in_stall_o is high
//   for a whole query. Results are collected first, then sent, since
//   overflow is known only at the end of the search.
// Reset: config registers return to their defaults; coordinate storage is
//   not cleared and must be written before it is queried.
// Stall: a stalled result holds in the output register and the sequencer
//   waits; the next item is taken while the last result is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_neighbor_search_core_defines.svh"

module periodic_neighbor_search_core #(
  parameter int MAX_ATOMS     = pns_pkg::MAX_ATOMS_DEF,
  parameter int MAX_NEIGHBORS = pns_pkg::MAX_NEIGHBORS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // command items
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  command_i,
  input  wire logic        [pns_pkg::IDX_W-1:0]      atom_index_i,
  input  wire logic signed [pns_pkg::COORD_W-1:0]    coord_x_i,
  input  wire logic signed [pns_pkg::COORD_W-1:0]    coord_y_i,
  input  wire logic signed [pns_pkg::COORD_W-1:0]    coord_z_i,
  // result items
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       found_o,
  output logic             [pns_pkg::IDX_W-1:0]      neighbor_index_o,
  output logic signed      [pns_pkg::SHIFT_W-1:0]    shift_x_o,
  output logic signed      [pns_pkg::SHIFT_W-1:0]    shift_y_o,
  output logic signed      [pns_pkg::SHIFT_W-1:0]    shift_z_o,
  output logic                                       overflow_o,
  output logic                                       last_o,
  // configuration writes
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic        [pns_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic        [pns_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pns_pkg::*;

  localparam int AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int NW  = $clog2(MAX_ATOMS + 1);
  localparam int NBW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int NCW = $clog2(MAX_NEIGHBORS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CENTER,
    S_FETCH,
    S_DIFF,
    S_SQ,
    S_ACC,
    S_CMP,
    S_FIN,
    S_EMIT_RD,
    S_EMIT_PUT,
    S_NONE
  } state_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic        [IDX_W-1:0]   idx;
    logic signed [SHIFT_W-1:0] sx;
    logic signed [SHIFT_W-1:0] sy;
    logic signed [SHIFT_W-1:0] sz;
  } res_entry_t;

  // configuration registers
  logic [PERIOD_W-1:0] period_x_q, period_y_q, period_z_q;
  logic [COUNT_W-1:0]  atom_count_q;
  logic [TGT_W-1:0]    target_q;
  logic [TOL_W-1:0]    tol_q;

  // sequencer
  state_e              state_q;
  axis_e               axis_q;
  logic [AW-1:0]       j_q;
  logic [NW-1:0]       n_q;
  logic [IDX_W-1:0]    qidx_q;
  logic signed [SHIFT_W-1:0] sx_q, sy_q, sz_q;
  logic [NCW-1:0]      cnt_q, k_q;
  logic                ovf_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;

  // output register
  logic                out_valid_q;
  logic                found_q, ovfo_q, last_q;
  logic [IDX_W-1:0]    nidx_q;
  logic signed [SHIFT_W-1:0] osx_q, osy_q, osz_q;

  // storage
  logic signed [COORD_W-1:0] x_mem [MAX_ATOMS];
  logic signed [COORD_W-1:0] y_mem [MAX_ATOMS];
  logic signed [COORD_W-1:0] z_mem [MAX_ATOMS];
  logic signed [COORD_W-1:0] rd_x_q, rd_y_q, rd_z_q;
  res_entry_t                buf_mem [MAX_NEIGHBORS];
  res_entry_t                buf_rd_q;

  // combinational helpers
  logic          in_acc;
  logic          idx_ok;
  logic [NW-1:0] n_in;
  logic [AW-1:0] rd_addr;
  logic          store_we, buf_we;
  logic          out_free;
  logic          j_last, all_last, skip_self, cnt_full;
  logic [AW-1:0] j_nx;
  logic signed [SHIFT_W-1:0] sx_nx, sy_nx, sz_nx;
  dist_ctl_t     dctl;
  logic signed [COORD_W-1:0] d_coord, d_center;
  logic signed [SHIFT_W-1:0] d_shift;
  logic [PERIOD_W-1:0]       d_period;
  logic          dist_match;
  res_entry_t    buf_wdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign idx_ok = (32'(atom_index_i) < MAX_ATOMS);
  assign n_in   = (32'(atom_count_q) > MAX_ATOMS) ? NW'(MAX_ATOMS) : NW'(atom_count_q);

  assign rd_addr  = (state_q == S_IDLE) ? AW'(atom_index_i) : j_q;
  assign store_we = in_acc && (command_i == CMD_STORE) && idx_ok;

  // candidate order: index fastest, then z, y, x shift
  assign j_last    = ((NW'(j_q) + NW'(1)) == n_q);
  assign all_last  = j_last && (sx_q == SHIFT_POS) && (sy_q == SHIFT_POS)
                     && (sz_q == SHIFT_POS);
  assign skip_self = (32'(j_q) == 32'(qidx_q)) && (sx_q == SHIFT_ZERO)
                     && (sy_q == SHIFT_ZERO) && (sz_q == SHIFT_ZERO);
  assign cnt_full  = (cnt_q == NCW'(MAX_NEIGHBORS));

  always_comb begin
    j_nx  = j_q + AW'(1);
    sx_nx = sx_q;
    sy_nx = sy_q;
    sz_nx = sz_q;
    if (j_last) begin
      j_nx = '0;
      if (sz_q != SHIFT_POS) begin
        sz_nx = sz_q + SHIFT_POS;
      end else begin
        sz_nx = SHIFT_NEG;
        if (sy_q != SHIFT_POS) begin
          sy_nx = sy_q + SHIFT_POS;
        end else begin
          sy_nx = SHIFT_NEG;
          sx_nx = sx_q + SHIFT_POS;
        end
      end
    end
  end

  // distance unit control
  always_comb begin
    dctl.op    = OP_NONE;
    dctl.first = (axis_q == AXIS_X);
    case (state_q)
      S_CENTER: dctl.op = OP_LOAD;
      S_DIFF:   dctl.op = OP_DIFF;
      S_SQ:     dctl.op = OP_SQ;
      S_ACC:    dctl.op = OP_ACC;
      default:  dctl.op = OP_NONE;
    endcase
  end

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        d_coord = rd_x_q; d_shift = sx_q; d_period = period_x_q; d_center = cx_q;
      end
      AXIS_Y: begin
        d_coord = rd_y_q; d_shift = sy_q; d_period = period_y_q; d_center = cy_q;
      end
      default: begin
        d_coord = rd_z_q; d_shift = sz_q; d_period = period_z_q; d_center = cz_q;
      end
    endcase
  end

  pns_dist_unit u_dist (
    .clk_i    (clk_i),
    .ctl_i    (dctl),
    .coord_i  (d_coord),
    .shift_i  (d_shift),
    .period_i (d_period),
    .center_i (d_center),
    .target_i (target_q),
    .tol_i    (tol_q),
    .match_o  (dist_match)
  );

  // coordinate storage: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      x_mem[AW'(atom_index_i)] <= coord_x_i;
      y_mem[AW'(atom_index_i)] <= coord_y_i;
      z_mem[AW'(atom_index_i)] <= coord_z_i;
    end
    rd_x_q <= x_mem[rd_addr];
    rd_y_q <= y_mem[rd_addr];
    rd_z_q <= z_mem[rd_addr];
  end

  // result buffer
  assign buf_we        = (state_q == S_CMP) && dist_match && !cnt_full;
  assign buf_wdata.idx = IDX_W'(j_q);
  assign buf_wdata.sx  = sx_q;
  assign buf_wdata.sy  = sy_q;
  assign buf_wdata.sz  = sz_q;

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[cnt_q[NBW-1:0]] <= buf_wdata;
    end
    buf_rd_q <= buf_mem[k_q[NBW-1:0]];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_x_q   <= PERIOD_RST;
      period_y_q   <= PERIOD_RST;
      period_z_q   <= PERIOD_RST;
      atom_count_q <= COUNT_RST;
      target_q     <= TGT_RST;
      tol_q        <= TOL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PERIOD_X:   period_x_q   <= cfg_data_i[PERIOD_W-1:0];
        CFG_PERIOD_Y:   period_y_q   <= cfg_data_i[PERIOD_W-1:0];
        CFG_PERIOD_Z:   period_z_q   <= cfg_data_i[PERIOD_W-1:0];
        CFG_ATOM_COUNT: atom_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_TARGET_SQ:  target_q     <= cfg_data_i[TGT_W-1:0];
        CFG_TOLERANCE:  tol_q        <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= AXIS_X;
      j_q         <= '0;
      n_q         <= '0;
      qidx_q      <= '0;
      sx_q        <= SHIFT_NEG;
      sy_q        <= SHIFT_NEG;
      sz_q        <= SHIFT_NEG;
      cnt_q       <= '0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      nidx_q      <= '0;
      osx_q       <= SHIFT_ZERO;
      osy_q       <= SHIFT_ZERO;
      osz_q       <= SHIFT_ZERO;
      ovfo_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && (command_i == CMD_QUERY)) begin
            qidx_q <= atom_index_i;
            n_q    <= n_in;
            cnt_q  <= '0;
            ovf_q  <= 1'b0;
            j_q    <= '0;
            sx_q   <= SHIFT_NEG;
            sy_q   <= SHIFT_NEG;
            sz_q   <= SHIFT_NEG;
            state_q <= (idx_ok && (n_in != '0)) ? S_CENTER : S_NONE;
          end
        end
        S_CENTER: begin
          cx_q    <= rd_x_q;
          cy_q    <= rd_y_q;
          cz_q    <= rd_z_q;
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          if (skip_self) begin
            j_q  <= j_nx;
            sx_q <= sx_nx;
            sy_q <= sy_nx;
            sz_q <= sz_nx;
            if (all_last) begin
              state_q <= S_FIN;
            end
          end else begin
            axis_q  <= AXIS_X;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: state_q <= S_SQ;
        S_SQ: begin
          case (axis_q)
            AXIS_X: begin
              axis_q  <= AXIS_Y;
              state_q <= S_DIFF;
            end
            AXIS_Y: begin
              axis_q  <= AXIS_Z;
              state_q <= S_DIFF;
            end
            default: state_q <= S_ACC;
          endcase
        end
        S_ACC: state_q <= S_CMP;
        S_CMP: begin
          if (dist_match) begin
            if (cnt_full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + NCW'(1);
            end
          end
          // a match past a full buffer settles the list; stop early
          if ((dist_match && cnt_full) || all_last) begin
            state_q <= S_FIN;
          end else begin
            j_q     <= j_nx;
            sx_q    <= sx_nx;
            sy_q    <= sy_nx;
            sz_q    <= sz_nx;
            state_q <= S_FETCH;
          end
        end
        S_FIN: begin
          k_q     <= '0;
          state_q <= (cnt_q == '0) ? S_NONE : S_EMIT_RD;
        end
        S_EMIT_RD: state_q <= S_EMIT_PUT;
        S_EMIT_PUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            found_q     <= 1'b1;
            nidx_q      <= buf_rd_q.idx;
            osx_q       <= buf_rd_q.sx;
            osy_q       <= buf_rd_q.sy;
            osz_q       <= buf_rd_q.sz;
            ovfo_q      <= ovf_q;
            last_q      <= ((k_q + NCW'(1)) == cnt_q);
            k_q         <= k_q + NCW'(1);
            state_q     <= ((k_q + NCW'(1)) == cnt_q) ? S_IDLE : S_EMIT_RD;
          end
        end
        S_NONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            found_q     <= 1'b0;
            nidx_q      <= '0;
            osx_q       <= SHIFT_ZERO;
            osy_q       <= SHIFT_ZERO;
            osz_q       <= SHIFT_ZERO;
            ovfo_q      <= 1'b0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign neighbor_index_o = nidx_q;
  assign shift_x_o        = osx_q;
  assign shift_y_o        = osy_q;
  assign shift_z_o        = osz_q;
  assign overflow_o       = ovfo_q;
  assign last_o           = last_q;

  // checks
  `PNS_ASSERT(a_cnt_bound, cnt_q <= NCW'(MAX_NEIGHBORS), "result count past buffer depth")
  `PNS_ASSERT(a_ovf_full, !ovf_q || cnt_full, "overflow flagged before buffer filled")
  `PNS_ASSERT(a_emit_range, (state_q != S_EMIT_PUT) || (k_q < cnt_q), "emit index past count")
  `PNS_ASSERT(a_none_last, !(out_valid_o && !found_o) || last_o, "not-found item without last")
  `PNS_ASSERT_NEXT(a_query_busy, in_acc && (command_i == CMD_QUERY), in_stall_o, "query not taken up")

endmodule

`default_nettype wire
